// ===== design/fdd_pkg.sv =====
// Shared types, widths and codes for the finite difference derivative block.
package fdd_pkg;

   // Field widths of the sample and result transactions.
   localparam int SAMPLE_WIDTH = 32;
   localparam int FRAC_BITS    = 16;
   localparam int OUT_WIDTH    = 48;
   localparam int INV_WIDTH    = 32;

   // Stencil sums reach twelve times a sample, so five guard bits cover them.
   localparam int NUM_WIDTH  = SAMPLE_WIDTH + 5;
   localparam int MAG_WIDTH  = SAMPLE_WIDTH + 4;
   localparam int PROD_WIDTH = MAG_WIDTH + 2 * INV_WIDTH;

   // Multiplier limb width and pipeline depths.
   localparam int LIMB_WIDTH    = 32;
   localparam int MUL_LATENCY   = 2;
   localparam int SCALE_LATENCY = 2 * MUL_LATENCY + 2;

   // Window length and the most results one sample can cause.
   localparam int WINDOW_DEPTH = 4;
   localparam int MAX_JOBS     = 4;
   localparam int QUEUE_DEPTH  = 2;

   // Register map: the index is the word address bit above the byte lanes.
   localparam int   CSR_ADDR_WIDTH  = 3;
   localparam logic REG_INV_SPACING = 1'b0;
   localparam logic [INV_WIDTH-1:0] INV_SPACING_RESET = INV_WIDTH'(1) << FRAC_BITS;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NO_SECOND   = 2'd1,
      ST_TOO_FEW     = 2'd2,
      ST_BAD_SPACING = 2'd3
   } status_type;

   // Final right shift applied after scaling.
   typedef enum logic [1:0] {
      SH_UNIT   = 2'd0,
      SH_HALF   = 2'd1,
      SH_SQUARE = 2'd2
   } shift_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           end_of_vector;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] first_deriv;
      logic signed [OUT_WIDTH-1:0] second_deriv;
      logic [1:0]                  status;
      logic                        final_point;
   } rsp_payload_type;

   // One window cell: a sample and whether it belongs to the current vector.
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           occupied;
   } cell_type;

   // One pending result: both stencil sums and the sideband that goes with them.
   typedef struct packed {
      logic signed [NUM_WIDTH-1:0] num_first;
      logic signed [NUM_WIDTH-1:0] num_second;
      shift_type                   first_shift;
      status_type                  status;
      logic                        final_point;
   } job_type;

endpackage

// ===== design/fdd_cell.sv =====
// One cell of the sample window chain.
module fdd_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  logic              clear,
   input  fdd_pkg::cell_type shift_in,
   output fdd_pkg::cell_type state
);

   fdd_pkg::cell_type state_ff;
   fdd_pkg::cell_type state_in;

   // Take the neighbour's sample on each transaction; empty the cell at a vector end.
   always_comb begin
      state_in = state_ff;
      if (shift) begin
         if (clear) begin
            state_in = '0;
         end else begin
            state_in = shift_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

// ===== design/fdd_mul.sv =====
// Two-stage multiplier of a wide unsigned operand by a 32-bit factor, split into limbs.
module fdd_mul #(
   parameter int IN_W = fdd_pkg::MAG_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic [IN_W-1:0]                      operand,
   input  logic [fdd_pkg::INV_WIDTH-1:0]        factor,
   output logic [IN_W+fdd_pkg::INV_WIDTH-1:0]   product
);

   localparam int LW     = fdd_pkg::LIMB_WIDTH;
   localparam int FW     = fdd_pkg::INV_WIDTH;
   localparam int LIMBS  = (IN_W + LW - 1) / LW;
   localparam int PAD_W  = LIMBS * LW;
   localparam int PART_W = LW + FW;
   localparam int ACC_W  = PAD_W + FW;
   localparam int OUT_W  = IN_W + FW;

   logic [PAD_W-1:0]  padded;
   logic [PART_W-1:0] part_ff [LIMBS];
   logic [PART_W-1:0] part_in [LIMBS];
   logic [ACC_W-1:0]  acc;
   logic [OUT_W-1:0]  product_ff;
   logic [OUT_W-1:0]  product_in;

   assign padded = PAD_W'(operand);

   // First stage: one limb-by-factor product per limb.
   always_comb begin
      for (int i = 0; i < LIMBS; i++) begin
         part_in[i] = part_ff[i];
         if (enable) begin
            part_in[i] = PART_W'(padded[i*LW +: LW]) * PART_W'(factor);
         end
      end
   end

   // Second stage: add the limb products at their weights.
   always_comb begin
      acc = '0;
      for (int i = 0; i < LIMBS; i++) begin
         acc = acc + (ACC_W'(part_ff[i]) << (i * LW));
      end
      product_in = product_ff;
      if (enable) begin
         product_in = OUT_W'(acc);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LIMBS; i++) begin
         part_ff[i] <= part_in[i];
      end
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== design/fdd_scale.sv =====
// Scaling pipeline: stencil sum times one or two factors, rounded, shifted and saturated.
module fdd_scale #(
   parameter int FRAC_BITS = fdd_pkg::FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  enable,
   input  logic signed [fdd_pkg::NUM_WIDTH-1:0]  numerator,
   input  logic [fdd_pkg::INV_WIDTH-1:0]         inv_spacing,
   input  logic [fdd_pkg::INV_WIDTH-1:0]         factor_b,
   input  fdd_pkg::shift_type                    shift,
   output logic signed [fdd_pkg::OUT_WIDTH-1:0]  result
);

   localparam int MW    = fdd_pkg::MAG_WIDTH;
   localparam int FW    = fdd_pkg::INV_WIDTH;
   localparam int OW    = fdd_pkg::OUT_WIDTH;
   localparam int A_W   = MW + FW;
   localparam int P_W   = fdd_pkg::PROD_WIDTH;
   localparam int SUM_W = P_W + 1;
   localparam int MUL_D = 2 * fdd_pkg::MUL_LATENCY;
   localparam int ML    = fdd_pkg::MUL_LATENCY;

   localparam logic [SUM_W-1:0] HALF_UNIT   = SUM_W'(1) << (FRAC_BITS - 1);
   localparam logic [SUM_W-1:0] HALF_HALF   = SUM_W'(1) << FRAC_BITS;
   localparam logic [SUM_W-1:0] HALF_SQUARE = SUM_W'(1) << (2 * FRAC_BITS - 1);
   localparam logic [SUM_W-1:0] NEG_LIMIT   = SUM_W'(1) << (OW - 1);
   localparam logic [SUM_W-1:0] POS_LIMIT   = NEG_LIMIT - SUM_W'(1);

   logic                  neg;
   logic [MW-1:0]         mag;
   logic [A_W-1:0]        prod_a;
   logic [P_W-1:0]        prod_b;

   logic                  neg_ff [MUL_D];
   logic                  neg_in [MUL_D];
   fdd_pkg::shift_type    sh_ff  [MUL_D];
   fdd_pkg::shift_type    sh_in  [MUL_D];
   logic [FW-1:0]         fb_ff  [ML];
   logic [FW-1:0]         fb_in  [ML];

   logic [SUM_W-1:0]      half;
   logic [SUM_W-1:0]      sum;
   logic [SUM_W-1:0]      shifted;
   logic [SUM_W-1:0]      rounded_ff;
   logic [SUM_W-1:0]      rounded_in;
   logic                  neg_round_ff;
   logic                  neg_round_in;

   logic [SUM_W-1:0]      limit;
   logic [SUM_W-1:0]      mag_sat;
   logic signed [OW-1:0]  result_ff;
   logic signed [OW-1:0]  result_in;

   // Work on the magnitude; the sign rides alongside and is put back at the end.
   assign neg = numerator[fdd_pkg::NUM_WIDTH-1];
   assign mag = MW'(neg ? -numerator : numerator);

   fdd_mul #(.IN_W(MW)) u_mul_a (
      .clock   (clock),
      .enable  (enable),
      .operand (mag),
      .factor  (inv_spacing),
      .product (prod_a)
   );

   fdd_mul #(.IN_W(A_W)) u_mul_b (
      .clock   (clock),
      .enable  (enable),
      .operand (prod_a),
      .factor  (fb_ff[ML-1]),
      .product (prod_b)
   );

   // Sideband delay lines matched to the multiplier stages.
   always_comb begin
      for (int i = 0; i < MUL_D; i++) begin
         neg_in[i] = neg_ff[i];
         sh_in[i]  = sh_ff[i];
      end
      for (int i = 0; i < ML; i++) begin
         fb_in[i] = fb_ff[i];
      end
      if (enable) begin
         neg_in[0] = neg;
         sh_in[0]  = shift;
         fb_in[0]  = factor_b;
         for (int i = 1; i < MUL_D; i++) begin
            neg_in[i] = neg_ff[i-1];
            sh_in[i]  = sh_ff[i-1];
         end
         for (int i = 1; i < ML; i++) begin
            fb_in[i] = fb_ff[i-1];
         end
      end
   end

   // Round to nearest with halves away from zero, then drop the fraction bits.
   always_comb begin
      case (sh_ff[MUL_D-1])
         fdd_pkg::SH_UNIT:   half = HALF_UNIT;
         fdd_pkg::SH_HALF:   half = HALF_HALF;
         fdd_pkg::SH_SQUARE: half = HALF_SQUARE;
         default:            half = HALF_HALF;
      endcase
      sum = SUM_W'(prod_b) + half;
      case (sh_ff[MUL_D-1])
         fdd_pkg::SH_UNIT:   shifted = sum >> FRAC_BITS;
         fdd_pkg::SH_HALF:   shifted = sum >> (FRAC_BITS + 1);
         fdd_pkg::SH_SQUARE: shifted = sum >> (2 * FRAC_BITS);
         default:            shifted = sum >> (FRAC_BITS + 1);
      endcase
      rounded_in   = rounded_ff;
      neg_round_in = neg_round_ff;
      if (enable) begin
         rounded_in   = shifted;
         neg_round_in = neg_ff[MUL_D-1];
      end
   end

   // Saturate the magnitude against the limit of its sign and restore the sign.
   always_comb begin
      limit     = neg_round_ff ? NEG_LIMIT : POS_LIMIT;
      mag_sat   = (rounded_ff > limit) ? limit : rounded_ff;
      result_in = result_ff;
      if (enable) begin
         result_in = neg_round_ff ? -OW'(mag_sat) : OW'(mag_sat);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MUL_D; i++) begin
         neg_ff[i] <= neg_in[i];
         sh_ff[i]  <= sh_in[i];
      end
      for (int i = 0; i < ML; i++) begin
         fb_ff[i] <= fb_in[i];
      end
      rounded_ff   <= rounded_in;
      neg_round_ff <= neg_round_in;
      result_ff    <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== design/finite_difference_derivatives.sv =====
// Top level of the streaming finite difference derivative block.
//
// Samples arrive on the req_ channel, one transaction per grid point, with
// end_of_vector set on the last sample of each vector.  Results leave on the
// rsp_ channel in point order: first and second derivative, status and a
// final_point flag on the last result of a vector or on an error result.
// The reciprocal spacing is written through the csr_ port at word 0.
// A sample window of four cells shifts on every accepted transaction.  Each
// sample causes between zero and four results; these are queued in a job
// buffer that hands one job per cycle to the scaling pipeline while the
// output queue has room.  A sample is taken in every cycle while it causes
// at most one result and the output queue has room; a sample that causes
// more results holds the input while the job buffer drains.  The first
// result of a sample passes the job buffer register and then the scaling
// pipeline (two limb multiplier stages per factor, one rounding and one
// saturation stage).  A two-entry output queue sits in front of the rsp_
// channel; while the receiver stalls, the queue fills and the pipeline and
// then the input stop.  Reset empties the window, the job buffer, the
// pipeline and the queue, and sets the reciprocal spacing to one.
module finite_difference_derivatives #(
   parameter int FRAC_BITS = fdd_pkg::FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  fdd_pkg::req_payload_type               req_payload,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output fdd_pkg::rsp_payload_type               rsp_payload,

   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [fdd_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  logic [fdd_pkg::INV_WIDTH-1:0]          csr_pwdata,
   output logic [fdd_pkg::INV_WIDTH-1:0]          csr_prdata,
   output logic                                   csr_pready
);

   localparam int NW      = fdd_pkg::NUM_WIDTH;
   localparam int DEPTH   = fdd_pkg::WINDOW_DEPTH;
   localparam int JOBS    = fdd_pkg::MAX_JOBS;
   localparam int LAT     = fdd_pkg::SCALE_LATENCY;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int JOB_W   = $clog2(JOBS + 1);
   localparam int QD      = fdd_pkg::QUEUE_DEPTH;
   localparam int QC_W    = $clog2(QD + 1);
   localparam int QP_W    = $clog2(QD);

   localparam logic [fdd_pkg::INV_WIDTH-1:0] INV_RESET = fdd_pkg::INV_WIDTH'(1) << FRAC_BITS;

   // Configuration register.
   logic [fdd_pkg::INV_WIDTH-1:0] inv_spacing_ff;
   logic [fdd_pkg::INV_WIDTH-1:0] inv_spacing_in;
   logic                          csr_write;

   // Window chain.
   fdd_pkg::cell_type cells     [DEPTH];
   fdd_pkg::cell_type cell_feed [DEPTH];
   logic [COUNT_W-1:0] points_before;

   // Job buffer.
   fdd_pkg::job_type jobs_ff  [JOBS];
   fdd_pkg::job_type jobs_in  [JOBS];
   fdd_pkg::job_type new_jobs [JOBS];
   logic [JOB_W-1:0] new_count;
   logic [JOB_W-1:0] remain_ff;
   logic [JOB_W-1:0] remain_in;

   // Handshake and flow control.
   logic accept;
   logic adv;
   logic emit;
   logic push;
   logic pop;

   // Stencil operands: the window after this transaction's shift.
   logic signed [NW-1:0] xa;
   logic signed [NW-1:0] xb;
   logic signed [NW-1:0] xc;
   logic signed [NW-1:0] xd;

   // Pipeline sideband.
   logic [LAT-1:0]        pipe_valid_ff;
   logic [LAT-1:0]        pipe_valid_in;
   fdd_pkg::status_type   status_ff [LAT];
   fdd_pkg::status_type   status_in [LAT];
   logic [LAT-1:0]        final_ff;
   logic [LAT-1:0]        final_in;
   logic signed [fdd_pkg::OUT_WIDTH-1:0] first_result;
   logic signed [fdd_pkg::OUT_WIDTH-1:0] second_result;

   // Output queue.
   fdd_pkg::rsp_payload_type queue_ff [QD];
   fdd_pkg::rsp_payload_type queue_in [QD];
   fdd_pkg::rsp_payload_type push_item;
   logic [QC_W-1:0] count_ff;
   logic [QC_W-1:0] count_in;
   logic [QP_W-1:0] wr_ptr_ff;
   logic [QP_W-1:0] wr_ptr_in;
   logic [QP_W-1:0] rd_ptr_ff;
   logic [QP_W-1:0] rd_ptr_in;

   function automatic fdd_pkg::job_type make_job(
      input logic signed [NW-1:0] n1,
      input logic signed [NW-1:0] n2,
      input fdd_pkg::shift_type   sh,
      input fdd_pkg::status_type  st,
      input logic                 fin
   );
      fdd_pkg::job_type j;
      j.num_first   = n1;
      j.num_second  = n2;
      j.first_shift = sh;
      j.status      = st;
      j.final_point = fin;
      return j;
   endfunction

   // Configuration port: writes land in the access phase; reads are immediate.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == fdd_pkg::REG_INV_SPACING);
   assign csr_prdata = (csr_paddr[2] == fdd_pkg::REG_INV_SPACING) ? inv_spacing_ff : '0;

   always_comb begin
      inv_spacing_in = inv_spacing_ff;
      if (csr_write) begin
         inv_spacing_in = csr_pwdata;
      end
   end

   // Flow control: the pipeline moves while the output queue has room.
   assign adv       = (count_ff != QC_W'(QD));
   assign emit      = adv && (remain_ff != '0);
   assign req_stall = !((remain_ff == '0) || ((remain_ff == JOB_W'(1)) && adv));
   assign accept    = req_valid && !req_stall;

   // Window chain: each cell takes its right neighbour, the last takes the sample.
   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         if (i == DEPTH - 1) begin : g_last
            assign cell_feed[i] = '{sample: req_payload.sample, occupied: 1'b1};
         end else begin : g_mid
            assign cell_feed[i] = cells[i+1];
         end
         fdd_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (accept),
            .clear    (req_payload.end_of_vector),
            .shift_in (cell_feed[i]),
            .state    (cells[i])
         );
      end
   endgenerate

   // Points already in the vector, saturating at the window length.
   always_comb begin
      points_before = '0;
      for (int i = 0; i < DEPTH; i++) begin
         points_before = points_before + COUNT_W'(cells[i].occupied);
      end
   end

   assign xa = NW'(cells[1].sample);
   assign xb = NW'(cells[2].sample);
   assign xc = NW'(cells[3].sample);
   assign xd = NW'(req_payload.sample);

   // Results caused by this sample, with their stencil sums.
   always_comb begin
      for (int i = 0; i < JOBS; i++) begin
         new_jobs[i] = '0;
      end
      new_count = '0;
      if (inv_spacing_ff == '0) begin
         if (req_payload.end_of_vector) begin
            new_jobs[0] = make_job('0, '0, fdd_pkg::SH_HALF, fdd_pkg::ST_BAD_SPACING, 1'b1);
            new_count   = JOB_W'(1);
         end
      end else if (points_before == COUNT_W'(0)) begin
         if (req_payload.end_of_vector) begin
            new_jobs[0] = make_job('0, '0, fdd_pkg::SH_HALF, fdd_pkg::ST_TOO_FEW, 1'b1);
            new_count   = JOB_W'(1);
         end
      end else if (points_before == COUNT_W'(1)) begin
         // Two points: a plain difference, no second derivative.
         if (req_payload.end_of_vector) begin
            new_jobs[0] = make_job(xd - xc, '0, fdd_pkg::SH_UNIT, fdd_pkg::ST_NO_SECOND, 1'b0);
            new_jobs[1] = make_job(xd - xc, '0, fdd_pkg::SH_UNIT, fdd_pkg::ST_NO_SECOND, 1'b1);
            new_count   = JOB_W'(2);
         end
      end else if (points_before == COUNT_W'(2)) begin
         // Three points: one second derivative shared by all three.
         if (req_payload.end_of_vector) begin
            new_jobs[0] = make_job(-((xb <<< 1) + xb) + (xc <<< 2) - xd,
                                   xb - (xc <<< 1) + xd,
                                   fdd_pkg::SH_HALF, fdd_pkg::ST_OK, 1'b0);
            new_jobs[1] = make_job(xd - xb, xb - (xc <<< 1) + xd,
                                   fdd_pkg::SH_HALF, fdd_pkg::ST_OK, 1'b0);
            new_jobs[2] = make_job(xb - (xc <<< 2) + (xd <<< 1) + xd,
                                   xb - (xc <<< 1) + xd,
                                   fdd_pkg::SH_HALF, fdd_pkg::ST_OK, 1'b1);
            new_count   = JOB_W'(3);
         end
      end else if (points_before == COUNT_W'(3)) begin
         // Fourth sample: the start point and the first two central points.
         new_jobs[0] = make_job(-((xa <<< 1) + xa) + (xb <<< 2) - xc,
                                (xa <<< 1) - ((xb <<< 2) + xb) + (xc <<< 2) - xd,
                                fdd_pkg::SH_HALF, fdd_pkg::ST_OK, 1'b0);
         new_jobs[1] = make_job(xc - xa, xa - (xb <<< 1) + xc,
                                fdd_pkg::SH_HALF, fdd_pkg::ST_OK, 1'b0);
         new_jobs[2] = make_job(xd - xb, xb - (xc <<< 1) + xd,
                                fdd_pkg::SH_HALF, fdd_pkg::ST_OK, 1'b0);
         new_count   = JOB_W'(3);
         if (req_payload.end_of_vector) begin
            new_jobs[3] = make_job(xb - (xc <<< 2) + (xd <<< 1) + xd,
                                   -xa + (xb <<< 2) - ((xc <<< 2) + xc) + (xd <<< 1),
                                   fdd_pkg::SH_HALF, fdd_pkg::ST_OK, 1'b1);
            new_count   = JOB_W'(4);
         end
      end else begin
         // Steady state: the central point before this sample and, at a vector end, the end point.
         new_jobs[0] = make_job(xd - xb, xb - (xc <<< 1) + xd,
                                fdd_pkg::SH_HALF, fdd_pkg::ST_OK, 1'b0);
         new_count   = JOB_W'(1);
         if (req_payload.end_of_vector) begin
            new_jobs[1] = make_job(xb - (xc <<< 2) + (xd <<< 1) + xd,
                                   -xa + (xb <<< 2) - ((xc <<< 2) + xc) + (xd <<< 1),
                                   fdd_pkg::SH_HALF, fdd_pkg::ST_OK, 1'b1);
            new_count   = JOB_W'(2);
         end
      end
   end

   // Job buffer: the head leaves each advancing cycle, a new list loads on a transaction.
   always_comb begin
      for (int i = 0; i < JOBS; i++) begin
         jobs_in[i] = jobs_ff[i];
      end
      remain_in = remain_ff;
      if (emit) begin
         for (int i = 0; i < JOBS - 1; i++) begin
            jobs_in[i] = jobs_ff[i+1];
         end
         remain_in = remain_ff - JOB_W'(1);
      end
      if (accept) begin
         for (int i = 0; i < JOBS; i++) begin
            jobs_in[i] = new_jobs[i];
         end
         remain_in = new_count;
      end
   end

   // Scaling pipelines: first derivative by 1/h, second by 1/h squared.
   fdd_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_first (
      .clock       (clock),
      .enable      (adv),
      .numerator   (jobs_ff[0].num_first),
      .inv_spacing (inv_spacing_ff),
      .factor_b    (fdd_pkg::INV_WIDTH'(1)),
      .shift       (jobs_ff[0].first_shift),
      .result      (first_result)
   );

   fdd_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_second (
      .clock       (clock),
      .enable      (adv),
      .numerator   (jobs_ff[0].num_second),
      .inv_spacing (inv_spacing_ff),
      .factor_b    (inv_spacing_ff),
      .shift       (fdd_pkg::SH_SQUARE),
      .result      (second_result)
   );

   // Valid bits, status and final flag travel beside the scaling pipelines.
   always_comb begin
      pipe_valid_in = pipe_valid_ff;
      final_in      = final_ff;
      for (int i = 0; i < LAT; i++) begin
         status_in[i] = status_ff[i];
      end
      if (adv) begin
         pipe_valid_in = {pipe_valid_ff[LAT-2:0], emit};
         final_in      = {final_ff[LAT-2:0], jobs_ff[0].final_point};
         status_in[0]  = jobs_ff[0].status;
         for (int i = 1; i < LAT; i++) begin
            status_in[i] = status_ff[i-1];
         end
      end
   end

   // Output queue: two entries, so the rsp_ stall never reaches the input directly.
   assign push = adv && pipe_valid_ff[LAT-1];
   assign pop  = rsp_valid && !rsp_stall;

   always_comb begin
      push_item.first_deriv  = first_result;
      push_item.second_deriv = second_result;
      push_item.status       = status_ff[LAT-1];
      push_item.final_point  = final_ff[LAT-1];
      for (int i = 0; i < QD; i++) begin
         queue_in[i] = queue_ff[i];
      end
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         queue_in[wr_ptr_ff] = push_item;
         wr_ptr_in           = wr_ptr_ff + QP_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QP_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QC_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QC_W'(1);
      end
   end

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = queue_ff[rd_ptr_ff];

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_spacing_ff <= INV_RESET;
         remain_ff      <= '0;
         pipe_valid_ff  <= '0;
         count_ff       <= '0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
      end else begin
         inv_spacing_ff <= inv_spacing_in;
         remain_ff      <= remain_in;
         pipe_valid_ff  <= pipe_valid_in;
         count_ff       <= count_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      for (int i = 0; i < JOBS; i++) begin
         jobs_ff[i] <= jobs_in[i];
      end
      for (int i = 0; i < LAT; i++) begin
         status_ff[i] <= status_in[i];
      end
      final_ff <= final_in;
      for (int i = 0; i < QD; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

`ifndef SYNTHESIS
   // The output queue never holds more than its depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= QC_W'(QD))
      else $error("output queue overfilled");

   // A vector end leaves the whole window empty.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.end_of_vector |=> (points_before == '0))
      else $error("window not cleared after vector end");

   // Without room in the queue the pipeline holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(pipe_valid_ff))
      else $error("pipeline moved while output queue was full");

   // Without a new transaction the job buffer drains by one per advancing cycle.
   assert property (@(posedge clock) disable iff (reset)
      emit && !accept |=> remain_ff == $past(remain_ff) - JOB_W'(1))
      else $error("job buffer count slipped");
`endif

endmodule
